[hdl/rgbhsv_pkg.sv]
`timescale 1ns / 1ps
package rgbhsv_pkg;
  localparam int ChanW = 8;
  localparam int NumW = 21;   // 17 * hue numerator, below 17*360*255
  localparam int DenW = 17;   // 24*C for hue, M for saturation
  localparam int QuoW = 8;

  typedef struct packed {
    logic [NumW-1:0] hrem;
    logic [DenW-1:0] hden;
    logic [QuoW-1:0] hquo;
    logic [NumW-1:0] srem;
    logic [DenW-1:0] sden;
    logic [QuoW-1:0] squo;
    logic [ChanW-1:0] value;
  } div_state_t;
endpackage

[hdl/rgbhsv_if.sv]
`timescale 1ns / 1ps
interface rgbhsv_if #(parameter int W0 = 8, parameter int W1 = 8, parameter int W2 = 8);
  logic valid;
  logic ready;
  logic [W0-1:0] f0;
  logic [W1-1:0] f1;
  logic [W2-1:0] f2;
  modport source (output valid, output f0, output f1, output f2, input ready);
  modport sink (input valid, input f0, input f1, input f2, output ready);
endinterface

[hdl/rgbhsv_prep.sv]
`timescale 1ns / 1ps
module rgbhsv_prep import rgbhsv_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output div_state_t       st_r
);
  logic [ChanW-1:0] mx, mn, c;
  logic signed [9:0] diff;
  logic signed [19:0] num;
  logic [19:0] num_u;
  div_state_t st_nxt;

  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
    c = mx - mn;
    if (mx == blue) begin
      diff = $signed({2'b00, red}) - $signed({2'b00, green});
      num = 20'sd240 * $signed({12'd0, c}) + 20'sd60 * 20'(diff);
    end else if (mx == green) begin
      diff = $signed({2'b00, blue}) - $signed({2'b00, red});
      num = 20'sd120 * $signed({12'd0, c}) + 20'sd60 * 20'(diff);
    end else begin
      diff = $signed({2'b00, green}) - $signed({2'b00, blue});
      num = 20'sd60 * 20'(diff);
    end
    if (num < 0) num = num + 20'sd360 * $signed({12'd0, c});
    num_u = num;
    // hue = floor(num*255/(360c)) = floor((num*17)/(24c)), num*17 < 2^21
    st_nxt.hrem = NumW'(num_u) * NumW'(17);
    st_nxt.hden = DenW'({9'd0, c} * 17'd24);
    st_nxt.hquo = '0;
    st_nxt.srem = NumW'({9'd0, c} * 17'd255);
    st_nxt.sden = {9'd0, mx};
    st_nxt.squo = '0;
    st_nxt.value = mx;
    if (c == '0) begin
      st_nxt.hrem = '0;
      st_nxt.hden = 17'd1;
      st_nxt.srem = '0;
      st_nxt.sden = 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end
endmodule

[hdl/rgbhsv_cell.sv]
`timescale 1ns / 1ps
// One restoring-division cell: settles quotient bit Bit of both quotients.
module rgbhsv_cell import rgbhsv_pkg::*; #(parameter int Bit = 0) (
  input  logic       clk,
  input  logic       en,
  input  div_state_t st_in,
  output div_state_t st_r
);
  localparam int ShW = NumW + QuoW;

  logic [ShW-1:0] hsh, ssh;
  div_state_t st_nxt;

  always_comb begin
    st_nxt = st_in;
    hsh = ShW'(st_in.hden) << Bit;
    ssh = ShW'(st_in.sden) << Bit;
    if ({{QuoW{1'b0}}, st_in.hrem} >= hsh) begin
      st_nxt.hrem = NumW'({{QuoW{1'b0}}, st_in.hrem} - hsh);
      st_nxt.hquo[Bit] = 1'b1;
    end
    if ({{QuoW{1'b0}}, st_in.srem} >= ssh) begin
      st_nxt.srem = NumW'({{QuoW{1'b0}}, st_in.srem} - ssh);
      st_nxt.squo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r <= st_nxt;
  end
endmodule

[hdl/rgb_to_hsv_pixel.sv]
`timescale 1ns / 1ps
// RGB to HSV pixel converter, 8 bits a channel.
// Input channel in_ carries red, green, blue; result channel out_ carries
// hue, saturation and value. A pixel transfers when valid and ready are high.
// Throughput: one pixel per clock while the receiver takes results. One
// stage finds max, min, chroma and the hue numerator,
// then a chain of eight division cells, one cell per quotient bit,
// resolves hue and saturation side by side.
// The whole pipe advances together; when the receiver stalls with a result
// waiting, the pipe holds and in_ready drops, so nothing is lost. While the
// last stage is empty the pipe keeps advancing even if the receiver stalls.
// Reset (rst_n low, synchronous) clears all stage valid bits; the pixel
// data registers themselves are not reset.
module rgb_to_hsv_pixel import rgbhsv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rgbhsv_if.sink   in_if,
  rgbhsv_if.source out_if
);
  localparam int Cells = QuoW;

  logic [Cells:0] vld_r;
  logic adv;
  div_state_t st [Cells+1];

  assign adv = !vld_r[Cells] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Cells-1:0], in_if.valid};
    end
  end

  rgbhsv_prep u_prep (
    .clk(clk), .en(adv), .red(in_if.f0), .green(in_if.f1), .blue(in_if.f2),
    .st_r(st[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    rgbhsv_cell #(.Bit(Cells - 1 - i)) u_cell (
      .clk(clk), .en(adv), .st_in(st[i]), .st_r(st[i+1])
    );
  end

  assign out_if.valid = vld_r[Cells];
  assign out_if.f0 = st[Cells].hquo;
  assign out_if.f1 = st[Cells].squo;
  assign out_if.f2 = st[Cells].value;
endmodule

[tb/hsv_scoreboard.sv]
`timescale 1ns / 1ps
module hsv_scoreboard (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [7:0] out_hue,
  input  logic [7:0] out_sat,
  input  logic [7:0] out_value,
  output int   errors,
  output int   pending
);
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] value;
  } hsv_t;

  hsv_t hsv_q[$];

  function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsv_t px;
    int mx, mn, chroma, base, diff, num;
    mx = int'(r); if (int'(g) > mx) mx = int'(g); if (int'(b) > mx) mx = int'(b);
    mn = int'(r); if (int'(g) < mn) mn = int'(g); if (int'(b) < mn) mn = int'(b);
    chroma = mx - mn;
    px.value = mx[7:0];
    px.sat = (mx != 0) ? 8'((chroma * 255) / mx) : 8'd0;
    px.hue = 8'd0;
    if (chroma != 0) begin
      // tie order: blue over green over red
      if (mx == int'(b)) begin
        base = 240; diff = int'(r) - int'(g);
      end else if (mx == int'(g)) begin
        base = 120; diff = int'(b) - int'(r);
      end else begin
        base = 0; diff = int'(g) - int'(b);
      end
      num = base * chroma + 60 * diff;
      if (num < 0) num += 360 * chroma;
      px.hue = 8'((num * 255) / (360 * chroma));
    end
    return px;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    if (rst_n) begin
      if (in_valid && in_ready) hsv_q.push_back(convert_pixel(in_red, in_green, in_blue));
      if (out_valid && out_ready) begin
        if (hsv_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer: h=%0d s=%0d v=%0d",
                                     out_hue, out_sat, out_value);
        end else begin
          want = hsv_q.pop_front();
          if (want.hue !== out_hue || want.sat !== out_sat || want.value !== out_value) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                       want.hue, want.sat, want.value, out_hue, out_sat, out_value);
          end
        end
      end
    end
    pending = hsv_q.size();
  end
endmodule

[tb/tb_rgb_to_hsv_pixel.sv]
`timescale 1ns / 1ps
module tb_rgb_to_hsv_pixel;
  import rgbhsv_pkg::*;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   hold_cycles;
  bit   hold_req;
  longint cycles;

  rgbhsv_if #(8, 8, 8) in_if ();
  rgbhsv_if #(8, 8, 8) out_if ();

  rgb_to_hsv_pixel dut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  hsv_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_red(in_if.f0), .in_green(in_if.f1), .in_blue(in_if.f2),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_hue(out_if.f0), .out_sat(out_if.f1), .out_value(out_if.f2),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    bit hold_taken;
    out_if.ready = 1'b0;
    hold_cycles = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_cycles = 60;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.f0 <= r;
    in_if.f1 <= g;
    in_if.f2 <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0] r, g, b, lvl;
    hold_req = 1'b0;
    src_idle_pct = 14;
    snk_idle_pct = 58;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.f0 = '0;
    in_if.f1 = '0;
    in_if.f2 = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // black, white, grays, primaries, ties, negative-hue red
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd10);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd10, 8'd254);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd255);
    send_pixel(8'd0, 8'd1, 8'd255);

    // fill the pipe against a stalled receiver
    hold_req = 1'b1;
    repeat (40) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 58 : 0;
      snk_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 14 : 0;
      repeat (630) begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        lvl = 8'($urandom);
        case ($urandom_range(7))
          0: begin g = r; b = r; end                  // gray
          1: g = r;                                   // red/green tie
          2: b = g;                                   // green/blue tie
          3: b = r;                                   // red/blue tie
          4: begin r = 8'hff; b = lvl; g = lvl >> 1; end // red max, green low
          default: ;
        endcase
        send_pixel(r, g, b);
      end
      drain_results();
    end

    repeat (40) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
